// ===== hw/rtl/region_bump_allocator_top_macros.svh =====
// assertion macros for the region bump allocator checker
`ifndef REGION_BUMP_ALLOCATOR_TOP_MACROS_SVH
`define REGION_BUMP_ALLOCATOR_TOP_MACROS_SVH

// same-cycle implication, sampled on clk, off during reset
`define RBA_ASSERT_SAME(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("rba check failed");

// next-cycle implication, sampled on clk, off during reset
`define RBA_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("rba check failed");

`endif

// ===== hw/rtl/rba_pkg.sv =====
// shared types and constants for the region bump allocator
`timescale 1ns / 1ps
`default_nettype none

package rba_pkg;

  localparam int MAX_REGIONS = 256;
  localparam int IDX_W       = $clog2(MAX_REGIONS);
  localparam int CNT_W       = 9;
  localparam int ADDR_W      = 32;
  localparam int SIZE_W      = ADDR_W + 1;
  localparam int PAGE_BYTES  = 4096;
  localparam int ALIGN_BYTES = 32;

  typedef enum logic [1:0] {
    REQ_LOAD  = 2'd0,
    REQ_ALIGN = 2'd1,
    REQ_PAGE  = 2'd2,
    REQ_NOP   = 2'd3
  } rba_req_t;

  typedef enum logic [1:0] {
    RES_OK,
    RES_FAIL,
    RES_ADDR
  } rba_res_t;

  typedef struct packed {
    rba_req_t            req_type;
    logic [IDX_W-1:0]    region_index;
    logic [ADDR_W-1:0]   region_base;
    logic [ADDR_W-1:0]   region_length;
    logic                region_available;
    logic [ADDR_W-1:0]   alloc_size;
  } rba_in_t;

  typedef struct packed {
    logic                status;
    logic [ADDR_W-1:0]   address;
  } rba_out_t;

  typedef struct packed {
    logic [ADDR_W-1:0]   base;
    logic [ADDR_W-1:0]   length;
    logic                available;
  } rba_ent_t;

  typedef struct packed {
    logic     cap;
    logic     load;
    logic     scan;
    logic     bump;
    logic     emit;
    rba_res_t res_sel;
  } rba_cmd_t;

  typedef struct packed {
    logic fit;
    logic scan_end;
  } rba_sts_t;

endpackage

`default_nettype wire

// ===== hw/rtl/rba_datapath.sv =====
// region tables, first-fit scan datapath and result register
`timescale 1ns / 1ps
`default_nettype none

module rba_datapath (
  input  wire logic                    clk,
  input  wire logic                    rst_n,
  input  wire rba_pkg::rba_cmd_t       cmd,
  output rba_pkg::rba_sts_t            sts,
  input  wire rba_pkg::rba_in_t        in_req,
  input  wire logic                    cfg_we,
  input  wire logic [rba_pkg::CNT_W-1:0] cfg_wdata,
  output rba_pkg::rba_out_t            out_res
);
  import rba_pkg::*;

  localparam logic [SIZE_W-1:0] ALIGN_MASK = SIZE_W'(ALIGN_BYTES - 1);
  localparam logic [ADDR_W-1:0] PAGE_MASK  = ADDR_W'(PAGE_BYTES - 1);

  logic [CNT_W-1:0]  count_r;
  logic [CNT_W-1:0]  limit;
  logic [CNT_W-1:0]  issue_r;
  logic              pend_r;
  logic              rd_en;
  logic [IDX_W-1:0]  rd_addr;
  logic [IDX_W-1:0]  eval_idx_r;
  logic [SIZE_W-1:0] size_r;
  logic [SIZE_W-1:0] size_nxt;
  logic              page_r;

  rba_ent_t          ent_mem_r [MAX_REGIONS];
  logic [ADDR_W-1:0] off_mem_r [MAX_REGIONS];
  rba_ent_t          ent_rd_r;
  logic [ADDR_W-1:0] off_rd_r;

  logic [SIZE_W:0]   end_sum;
  logic              fit;
  logic [IDX_W-1:0]  hit_idx_r;
  logic [ADDR_W-1:0] hit_off_r;
  logic [ADDR_W-1:0] hit_addr_r;
  logic [ADDR_W-1:0] page_addr;
  rba_out_t          out_r;
  rba_out_t          out_nxt;

  // region count register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r <= '0;
    end else if (cfg_we) begin
      count_r <= cfg_wdata;
    end
  end

  assign limit = (count_r > CNT_W'(MAX_REGIONS)) ? CNT_W'(MAX_REGIONS) : count_r;

  // request size: rounded up to ALIGN_BYTES, or padded by one page for page requests
  always_comb begin
    if (in_req.req_type == REQ_PAGE) begin
      size_nxt = {1'b0, in_req.alloc_size} + SIZE_W'(PAGE_BYTES);
    end else begin
      size_nxt = ({1'b0, in_req.alloc_size} + ALIGN_MASK) & ~ALIGN_MASK;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.cap) begin
      size_r <= size_nxt;
      page_r <= (in_req.req_type == REQ_PAGE);
    end
  end

  // scan read pointer
  assign rd_en   = cmd.scan && (issue_r < limit);
  assign rd_addr = issue_r[IDX_W-1:0];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pend_r  <= 1'b0;
      issue_r <= '0;
    end else if (cmd.cap) begin
      pend_r  <= 1'b0;
      issue_r <= '0;
    end else if (cmd.scan) begin
      pend_r <= rd_en;
      if (rd_en) begin
        issue_r <= issue_r + 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      eval_idx_r <= rd_addr;
    end
  end

  // region entry memory
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      ent_mem_r[in_req.region_index] <= '{base:      in_req.region_base,
                                          length:    in_req.region_length,
                                          available: in_req.region_available};
    end
    if (rd_en) begin
      ent_rd_r <= ent_mem_r[rd_addr];
    end
  end

  // used offset memory
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      off_mem_r[in_req.region_index] <= '0;
    end else if (cmd.bump) begin
      off_mem_r[hit_idx_r] <= hit_off_r;
    end
    if (rd_en) begin
      off_rd_r <= off_mem_r[rd_addr];
    end
  end

  // fits when the entry is available and offset plus size stays within length
  assign end_sum = {2'b00, off_rd_r} + {1'b0, size_r};
  assign fit     = pend_r && ent_rd_r.available
                   && (end_sum <= {2'b00, ent_rd_r.length});

  assign sts.fit      = fit;
  assign sts.scan_end = !pend_r && (issue_r >= limit);

  always_ff @(posedge clk) begin
    if (cmd.scan && fit) begin
      hit_idx_r  <= eval_idx_r;
      hit_off_r  <= end_sum[ADDR_W-1:0];
      hit_addr_r <= ent_rd_r.base + off_rd_r;
    end
  end

  assign page_addr = (hit_addr_r + PAGE_MASK) & ~PAGE_MASK;

  always_comb begin
    unique case (cmd.res_sel)
      RES_FAIL: out_nxt = '{status: 1'b1, address: '0};
      RES_ADDR: out_nxt = '{status: 1'b0, address: page_r ? page_addr : hit_addr_r};
      default:  out_nxt = '{status: 1'b0, address: '0};
    endcase
  end

  always_ff @(posedge clk) begin
    if (cmd.emit) begin
      out_r <= out_nxt;
    end
  end

  assign out_res = out_r;

endmodule

`default_nettype wire

// ===== hw/rtl/rba_ctrl.sv =====
// request sequencer for the region bump allocator
`timescale 1ns / 1ps
`default_nettype none

module rba_ctrl (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              start,
  input  wire rba_pkg::rba_req_t req_type,
  input  wire rba_pkg::rba_sts_t sts,
  output rba_pkg::rba_cmd_t      cmd,
  output logic                   busy,
  output logic                   out_valid
);
  import rba_pkg::*;

  typedef enum logic [1:0] {
    S_IDLE,
    S_SCAN,
    S_BUMP
  } state_t;

  state_t state_r;
  state_t state_nxt;
  logic   out_valid_r;

  always_comb begin
    cmd       = '{cap: 1'b0, load: 1'b0, scan: 1'b0, bump: 1'b0, emit: 1'b0,
                  res_sel: RES_OK};
    state_nxt = state_r;
    unique case (state_r)
      S_IDLE: begin
        if (start) begin
          unique case (req_type)
            REQ_LOAD: begin
              cmd.load = 1'b1;
              cmd.emit = 1'b1;
            end
            REQ_ALIGN, REQ_PAGE: begin
              cmd.cap   = 1'b1;
              state_nxt = S_SCAN;
            end
            default: begin
              cmd.emit = 1'b1;
            end
          endcase
        end
      end
      S_SCAN: begin
        cmd.scan = 1'b1;
        if (sts.fit) begin
          state_nxt = S_BUMP;
        end else if (sts.scan_end) begin
          cmd.emit    = 1'b1;
          cmd.res_sel = RES_FAIL;
          state_nxt   = S_IDLE;
        end
      end
      S_BUMP: begin
        cmd.bump    = 1'b1;
        cmd.emit    = 1'b1;
        cmd.res_sel = RES_ADDR;
        state_nxt   = S_IDLE;
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= cmd.emit;
    end
  end

  assign busy      = (state_r != S_IDLE);
  assign out_valid = out_valid_r;

endmodule

`default_nettype wire

// ===== hw/rtl/region_bump_allocator_top.sv =====
// top level of the region bump allocator
// load and unused request types: result registered in the cycle after the request, no busy time
// allocate: first-fit scan of the first region_count entries (at most 256), then a bump on a hit;
//   the result is registered after the bump, or at scan end on a miss; one request at a time
// the scan reads one region entry per cycle through a single memory read port
// synchronous active-low reset clears region_count and control; tables are undefined
`timescale 1ns / 1ps
`default_nettype none

module region_bump_allocator_top (
  input  wire logic                      clk,
  input  wire logic                      rst_n,
  input  wire logic                      start,
  output logic                           busy,
  input  wire rba_pkg::rba_in_t          in_req,
  output logic                           out_valid,
  output rba_pkg::rba_out_t              out_res,
  input  wire logic                      cfg_we,
  input  wire logic [rba_pkg::CNT_W-1:0] cfg_wdata
);
  import rba_pkg::*;

  rba_cmd_t cmd;
  rba_sts_t sts;

  rba_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (start),
    .req_type  (in_req.req_type),
    .sts       (sts),
    .cmd       (cmd),
    .busy      (busy),
    .out_valid (out_valid)
  );

  rba_datapath u_dp (
    .clk       (clk),
    .rst_n     (rst_n),
    .cmd       (cmd),
    .sts       (sts),
    .in_req    (in_req),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata),
    .out_res   (out_res)
  );

endmodule

`default_nettype wire

// ===== hw/rtl/rba_checker.sv =====
// port-level checks for the region bump allocator and their bind
`timescale 1ns / 1ps
`default_nettype none
`include "region_bump_allocator_top_macros.svh"

module rba_checker (
  input wire logic                      clk,
  input wire logic                      rst_n,
  input wire logic                      start,
  input wire logic                      busy,
  input wire rba_pkg::rba_in_t          in_req,
  input wire logic                      out_valid,
  input wire rba_pkg::rba_out_t         out_res,
  input wire logic                      cfg_we
);
  import rba_pkg::*;

  logic accept;
  logic alloc_req;

  assign accept    = start && !busy;
  assign alloc_req = (in_req.req_type == REQ_ALIGN) || (in_req.req_type == REQ_PAGE);

  // a failed request carries a zero address
  `RBA_ASSERT_SAME(a_fail_addr_zero, out_valid && out_res.status, out_res.address == '0)

  // results only come out while no request is in progress
  `RBA_ASSERT_SAME(a_out_when_idle, out_valid, !busy)

  // region count is only written while idle
  `RBA_ASSERT_SAME(a_cfg_when_idle, cfg_we, !busy)

  // a load request answers in the next cycle
  `RBA_ASSERT_NEXT(a_load_answer, accept && (in_req.req_type == REQ_LOAD), out_valid)

  // an allocate request holds the block busy
  `RBA_ASSERT_NEXT(a_alloc_busy, accept && alloc_req, busy && !out_valid)

endmodule

bind region_bump_allocator_top rba_checker u_rba_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .start     (start),
  .busy      (busy),
  .in_req    (in_req),
  .out_valid (out_valid),
  .out_res   (out_res),
  .cfg_we    (cfg_we)
);

`default_nettype wire

// ===== tb/region_bump_allocator_checker.sv =====
// reply checker for the region bump allocator: mirrors the region table and compares each reply
`timescale 1ns / 1ps

module region_bump_allocator_checker (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      start,
  input  logic                      busy,
  input  rba_pkg::rba_in_t          in_req,
  input  logic                      out_valid,
  input  rba_pkg::rba_out_t         out_res,
  input  logic                      cfg_we,
  input  logic [rba_pkg::CNT_W-1:0] cfg_wdata,
  output int                        mismatch_count,
  output int                        replies_due
);
  import rba_pkg::*;

  localparam logic STATUS_OK       = 1'b0;
  localparam logic STATUS_NO_SPACE = 1'b1;

  logic [ADDR_W-1:0] reg_base      [MAX_REGIONS];
  logic [ADDR_W-1:0] reg_length    [MAX_REGIONS];
  logic              reg_avail     [MAX_REGIONS];
  logic [ADDR_W-1:0] reg_watermark [MAX_REGIONS];
  logic [CNT_W-1:0]  region_count;
  rba_out_t          alloc_replies_q[$];

  // applies one request to the mirrored table and returns the reply it earns
  function automatic rba_out_t bump_allocate(input rba_in_t req);
    rba_out_t    reply;
    logic [32:0] need;
    logic [32:0] room;
    logic [32:0] rounded;
    logic [31:0] addr;
    int          limit;
    bit          found;
    reply.status  = STATUS_OK;
    reply.address = '0;
    found         = 1'b0;
    addr          = '0;
    need          = '0;
    limit = (int'(region_count) > MAX_REGIONS) ? MAX_REGIONS : int'(region_count);
    case (req.req_type)
      REQ_LOAD: begin
        reg_base[req.region_index]      = req.region_base;
        reg_length[req.region_index]    = req.region_length;
        reg_avail[req.region_index]     = req.region_available;
        reg_watermark[req.region_index] = '0;
      end
      REQ_ALIGN, REQ_PAGE: begin
        if (req.req_type == REQ_ALIGN) begin
          need = (({1'b0, req.alloc_size} + 33'(ALIGN_BYTES - 1)) / 33'(ALIGN_BYTES))
                 * 33'(ALIGN_BYTES);
        end else begin
          need = {1'b0, req.alloc_size} + 33'(PAGE_BYTES);
        end
        for (int i = 0; i < limit && !found; i++) begin
          if (reg_avail[i]) begin
            room = (reg_watermark[i] > reg_length[i]) ? 33'd0 :
                   {1'b0, reg_length[i] - reg_watermark[i]};
            if (room >= need) begin
              addr             = reg_base[i] + reg_watermark[i];
              reg_watermark[i] = reg_watermark[i] + need[31:0];
              found            = 1'b1;
            end
          end
        end
        if (found) begin
          if (req.req_type == REQ_PAGE) begin
            rounded = (({1'b0, addr} + 33'(PAGE_BYTES - 1)) / 33'(PAGE_BYTES))
                      * 33'(PAGE_BYTES);
            addr = rounded[31:0];
          end
          reply.address = addr;
        end else begin
          reply.status = STATUS_NO_SPACE;
        end
      end
      default: ;
    endcase
    return reply;
  endfunction

  always @(posedge clk) begin
    rba_out_t want;
    if (!rst_n) begin
      region_count = '0;
      alloc_replies_q.delete();
      mismatch_count = 0;
    end else begin
      if (out_valid) begin
        if (alloc_replies_q.size() == 0) begin
          $error("reply with no request outstanding: status %0d address %h",
                 out_res.status, out_res.address);
          mismatch_count++;
        end else begin
          want = alloc_replies_q.pop_front();
          if (out_res.status !== want.status) begin
            $error("status mismatch: expected %0d, actual %0d", want.status, out_res.status);
            mismatch_count++;
          end
          if (out_res.address !== want.address) begin
            $error("address mismatch: expected %h, actual %h", want.address, out_res.address);
            mismatch_count++;
          end
        end
      end
      if (cfg_we) region_count = cfg_wdata;
      if (start && !busy) alloc_replies_q.push_back(bump_allocate(in_req));
    end
    replies_due = alloc_replies_q.size();
  end

endmodule

// ===== tb/testbench.sv =====
// testbench top for the region bump allocator: clock, reset, request stimulus and verdict
`timescale 1ns / 1ps

module testbench;
  import rba_pkg::*;

  localparam int ITEM_TARGET = 1600;

  logic             clk       = 1'b0;
  logic             rst_n     = 1'b0;
  logic             start     = 1'b0;
  rba_in_t          in_req    = '0;
  logic             cfg_we    = 1'b0;
  logic [CNT_W-1:0] cfg_wdata = '0;
  logic             busy;
  logic             out_valid;
  rba_out_t         out_res;
  int               mismatch_count;
  int               replies_due;
  int               items_sent = 0;
  bit               no_gaps    = 1'b0;

  region_bump_allocator_top dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (start),
    .busy      (busy),
    .in_req    (in_req),
    .out_valid (out_valid),
    .out_res   (out_res),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata)
  );

  region_bump_allocator_checker reply_check (
    .clk            (clk),
    .rst_n          (rst_n),
    .start          (start),
    .busy           (busy),
    .in_req         (in_req),
    .out_valid      (out_valid),
    .out_res        (out_res),
    .cfg_we         (cfg_we),
    .cfg_wdata      (cfg_wdata),
    .mismatch_count (mismatch_count),
    .replies_due    (replies_due)
  );

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  initial begin
    #50_000_000;
    $display("CHECKS FAILED");
    $finish;
  end

  function automatic rba_in_t load_req(input logic [IDX_W-1:0] idx,
                                       input logic [ADDR_W-1:0] base,
                                       input logic [ADDR_W-1:0] len,
                                       input logic avail);
    rba_in_t req;
    req                  = '0;
    req.req_type         = REQ_LOAD;
    req.region_index     = idx;
    req.region_base      = base;
    req.region_length    = len;
    req.region_available = avail;
    return req;
  endfunction

  function automatic rba_in_t alloc_req(input rba_req_t mode, input logic [ADDR_W-1:0] nbytes);
    rba_in_t req;
    req            = '0;
    req.req_type   = mode;
    req.alloc_size = nbytes;
    return req;
  endfunction

  function automatic logic [ADDR_W-1:0] random_length();
    if ($urandom_range(0, 3) == 0) return $urandom;
    return $urandom_range(0, 'h3fff);
  endfunction

  // span is the number of entries the current region count lets the scan see
  function automatic rba_in_t random_request(input int span);
    rba_in_t     req;
    int unsigned pick;
    req.req_type         = REQ_NOP;
    req.region_index     = IDX_W'($urandom);
    req.region_base      = $urandom;
    req.region_length    = $urandom;
    req.region_available = 1'($urandom);
    req.alloc_size       = $urandom;
    pick = $urandom_range(0, 99);
    if (pick < 25) begin
      req.req_type = REQ_LOAD;
      if (span > 0 && $urandom_range(0, 3) != 0) begin
        req.region_index = IDX_W'($urandom_range(0, span - 1));
      end
      req.region_length    = random_length();
      req.region_available = ($urandom_range(0, 9) != 0);
    end else if (pick < 96) begin
      req.req_type = (pick < 60) ? REQ_ALIGN : REQ_PAGE;
      case ($urandom_range(0, 9))
        0: req.alloc_size = '0;
        1: req.alloc_size = '1;
        2: ;
        3: req.alloc_size = $urandom_range(0, 'h3f);
        default: req.alloc_size = $urandom_range(0, 'h7ff);
      endcase
    end
    return req;
  endfunction

  function automatic logic [CNT_W-1:0] pick_region_count(input int phase);
    int unsigned r;
    r = $urandom_range(0, 99);
    case (phase)
      0: return '1;
      1: return CNT_W'(MAX_REGIONS);
      2: return CNT_W'(MAX_REGIONS - 1);
      3: return '0;
      default: ;
    endcase
    if (r < 70) return CNT_W'($urandom_range(1, 8));
    if (r < 85) return CNT_W'($urandom_range(9, 40));
    if (r < 88) return '0;
    if (r < 96) return CNT_W'($urandom_range(41, MAX_REGIONS - 1));
    return CNT_W'($urandom_range(MAX_REGIONS, (1 << CNT_W) - 1));
  endfunction

  task automatic send_request(input rba_in_t req);
    int gap;
    gap = no_gaps ? 0 : $urandom_range(0, 6);
    if (gap > 0) begin
      start <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_req <= req;
    start  <= 1'b1;
    do @(posedge clk); while (busy);
    items_sent++;
  endtask

  // hold off until every reply is back and the block is idle
  task automatic drain();
    start <= 1'b0;
    @(negedge clk);
    while (replies_due != 0 || busy) @(negedge clk);
    @(posedge clk);
  endtask

  task automatic write_region_count(input logic [CNT_W-1:0] value);
    cfg_wdata <= value;
    cfg_we    <= 1'b1;
    @(posedge clk);
    cfg_we    <= 1'b0;
  endtask

  initial begin
    int               phase;
    int               span;
    int               run_len;
    logic [CNT_W-1:0] count_val;
    rba_in_t          idle_req;
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // nothing to scan yet
    write_region_count('0);
    send_request(alloc_req(REQ_ALIGN, 32'h40));
    send_request(alloc_req(REQ_PAGE, 32'h0));
    idle_req          = '1;
    idle_req.req_type = REQ_NOP;
    send_request(idle_req);
    send_request(load_req(8'd0, 32'h0000_1000, 32'h0000_0100, 1'b1));
    send_request(load_req(8'd1, 32'h2000_0000, 32'hffff_ffff, 1'b0));
    send_request(load_req(8'd2, 32'hffff_ff00, 32'hffff_ffff, 1'b1));
    send_request(load_req(8'd3, 32'hffff_ffff, 32'h0000_0000, 1'b1));
    send_request(load_req(8'hff, 32'hffff_ffff, 32'hffff_ffff, 1'b1));
    drain();
    write_region_count(CNT_W'(4));
    send_request(alloc_req(REQ_ALIGN, 32'h0));
    send_request(alloc_req(REQ_ALIGN, 32'h1));
    send_request(alloc_req(REQ_ALIGN, 32'he0));
    send_request(alloc_req(REQ_ALIGN, 32'h0));
    send_request(alloc_req(REQ_ALIGN, 32'h1));
    send_request(alloc_req(REQ_PAGE, 32'h0));
    send_request(alloc_req(REQ_ALIGN, 32'hffff_ffff));
    send_request(alloc_req(REQ_PAGE, 32'hffff_ffff));
    send_request(alloc_req(REQ_ALIGN, 32'hffff_efc0));
    idle_req          = '0;
    idle_req.req_type = REQ_NOP;
    send_request(idle_req);

    // fill the whole table so any region count is safe to scan
    drain();
    for (int i = 0; i < MAX_REGIONS; i++) begin
      send_request(load_req(IDX_W'(i), $urandom, random_length(), $urandom_range(0, 9) != 0));
    end

    phase = 0;
    while (items_sent < ITEM_TARGET) begin
      drain();
      count_val = pick_region_count(phase);
      write_region_count(count_val);
      span    = (int'(count_val) > MAX_REGIONS) ? MAX_REGIONS : int'(count_val);
      run_len = (span > 40) ? $urandom_range(12, 25) : $urandom_range(20, 80);
      no_gaps = ($urandom_range(0, 3) == 0);
      for (int k = 0; k < run_len; k++) begin
        if ($urandom_range(0, 24) == 0) drain();
        send_request(random_request(span));
      end
      phase++;
    end

    drain();
    repeat (300) @(posedge clk);
    if (mismatch_count == 0 && replies_due == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule
